FILE: rtl/rfb_pkg.sv
package rfb_pkg;

   localparam int HDR_LEN     = 8;
   localparam int BURST_CNT_W = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] MAX_PAYLOAD = 8'd255;

   localparam logic [7:0] SYNC_FIRST_RESET  = 8'd72;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'd101;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 1'b1;

   localparam logic [BURST_CNT_W-1:0] CNT_NONE      = 4'd0;
   localparam logic [BURST_CNT_W-1:0] CNT_ECHO      = 4'd1;
   localparam logic [BURST_CNT_W-1:0] CNT_ECHO_SUMS = 4'd3;
   localparam logic [BURST_CNT_W-1:0] CNT_HEADER    = 4'd8;

   // The bytes one item produces, lowest index first on the wire.
   typedef struct packed {
      logic [HDR_LEN-1:0][7:0]  data;
      logic [BURST_CNT_W-1:0]   count;
      logic                     closes;
   } burst_type;

endpackage

FILE: rtl/radio_frame_builder_fletcher.sv
// Channel   Handshake                Payload
// req       req_valid / req_ready    req_cmd, req_command_word, req_frame_length, req_data_byte
// rsp       rsp_valid / rsp_ready    rsp_out_byte, rsp_last
// csr       csr_write_enable         csr_index, csr_wdata
//
// An item's bytes appear from the cycle after it is taken, one per cycle while rsp_ready is high.
// A start item yields eight bytes, a payload item none, one or three; the output buffer
// sets the rate.
// A new item is taken in the same cycle that the last byte of the previous one leaves.
// Reset is synchronous and restores the default sync bytes and closes any open frame.
// A stall on rsp holds the current byte and blocks req until the buffer drains.
module radio_frame_builder_fletcher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [15:0]                    req_command_word,
   input  logic [7:0]                     req_frame_length,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last,
   input  logic                           csr_write_enable,
   input  logic [rfb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rfb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rfb_pkg::*;

   burst_type burst;
   logic      accept;

   assign accept = req_valid && req_ready;

   rfb_framer u_framer (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_cmd          (req_cmd),
      .req_command_word (req_command_word),
      .req_frame_length (req_frame_length),
      .req_data_byte    (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .burst            (burst)
   );

   rfb_burst_out u_burst_out (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .burst        (burst),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

FILE: rtl/rfb_framer.sv
module rfb_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          req_cmd,
   input  logic [15:0]                   req_command_word,
   input  logic [7:0]                    req_frame_length,
   input  logic [7:0]                    req_data_byte,
   input  logic                          csr_write_enable,
   input  logic [rfb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rfb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rfb_pkg::burst_type            burst
);
   import rfb_pkg::*;

   logic [7:0] sync_first_ff, sync_second_ff;
   logic       frame_open_ff, frame_open_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] sum_a_ff, sum_a_in;
   logic [7:0] sum_b_ff, sum_b_in;

   logic [7:0] len, c_hi, c_lo;
   logic [7:0] a2, b2, b3, ha, hb, a5, b5, a6, b6;
   logic [7:0] pa, pb;
   logic       final_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata[7:0];
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      len  = (req_frame_length > MAX_PAYLOAD) ? MAX_PAYLOAD : req_frame_length;
      c_hi = req_command_word[15:8];
      c_lo = req_command_word[7:0];

      // Header sums over command high, command low, a zero length high byte
      // and the length low byte.
      a2 = c_hi + c_lo;
      b2 = c_hi + a2;
      b3 = b2 + a2;
      ha = a2 + len;
      hb = b3 + ha;
      // The header checksum bytes themselves join the running frame sums.
      a5 = ha + ha;
      b5 = hb + a5;
      a6 = a5 + hb;
      b6 = b5 + a6;

      pa = sum_a_ff + req_data_byte;
      pb = sum_b_ff + pa;
      final_byte = (bytes_left_ff == 8'd1);

      frame_open_in = frame_open_ff;
      bytes_left_in = bytes_left_ff;
      sum_a_in      = sum_a_ff;
      sum_b_in      = sum_b_ff;
      burst         = '0;

      if (req_cmd == CMD_START) begin
         burst.data   = {hb, ha, len, 8'd0, c_lo, c_hi, sync_second_ff, sync_first_ff};
         burst.count  = CNT_HEADER;
         burst.closes = (len == 8'd0);
         if (len == 8'd0) begin
            frame_open_in = 1'b0;
            bytes_left_in = 8'd0;
            sum_a_in      = 8'd0;
            sum_b_in      = 8'd0;
         end else begin
            frame_open_in = 1'b1;
            bytes_left_in = len;
            sum_a_in      = a6;
            sum_b_in      = b6;
         end
      end else if (frame_open_ff) begin
         burst.data[0] = req_data_byte;
         burst.data[1] = pa;
         burst.data[2] = pb;
         bytes_left_in = bytes_left_ff - 8'd1;
         if (final_byte) begin
            burst.count   = CNT_ECHO_SUMS;
            burst.closes  = 1'b1;
            frame_open_in = 1'b0;
            sum_a_in      = 8'd0;
            sum_b_in      = 8'd0;
         end else begin
            burst.count = CNT_ECHO;
            sum_a_in    = pa;
            sum_b_in    = pb;
         end
      end else begin
         burst.count = CNT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 8'd0;
         sum_a_ff      <= 8'd0;
         sum_b_ff      <= 8'd0;
      end else if (accept) begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
      end
   end

endmodule

FILE: rtl/rfb_burst_out.sv
module rfb_burst_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  rfb_pkg::burst_type burst,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last
);
   import rfb_pkg::*;

   logic [HDR_LEN-1:0][7:0]  data_ff;
   logic [BURST_CNT_W-1:0]   cnt_ff;
   logic                     closes_ff;
   logic                     busy_ff;
   logic                     draining_last;

   assign draining_last = busy_ff && rsp_ready && (cnt_ff == CNT_ECHO);
   assign req_ready     = !busy_ff || draining_last;
   assign rsp_valid     = busy_ff;
   assign rsp_out_byte  = data_ff[0];
   assign rsp_last      = closes_ff && (cnt_ff == CNT_ECHO);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= CNT_NONE;
      end else if (accept && burst.count != CNT_NONE) begin
         busy_ff <= 1'b1;
         cnt_ff  <= burst.count;
      end else if (busy_ff && rsp_ready) begin
         busy_ff <= (cnt_ff != CNT_ECHO);
         cnt_ff  <= cnt_ff - CNT_ECHO;
      end
   end

   // The buffer shifts down one byte per delivered byte.
   always_ff @(posedge clock) begin
      if (accept && burst.count != CNT_NONE) begin
         data_ff   <= burst.data;
         closes_ff <= burst.closes;
      end else if (busy_ff && rsp_ready) begin
         data_ff <= {8'd0, data_ff[HDR_LEN-1:1]};
      end
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rfb_pkg::*;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 16;

   typedef struct {
      logic [7:0] value;
      logic       last;
   } wire_byte_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_ready;
   logic                  req_cmd          = CMD_START;
   logic [15:0]           req_command_word = '0;
   logic [7:0]            req_frame_length = '0;
   logic [7:0]            req_data_byte    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready        = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = CSR_SYNC_FIRST;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   // Shadow of the framer: sync registers and the open frame's running sums.
   logic [7:0] sync_first_q  = SYNC_FIRST_RESET;
   logic [7:0] sync_second_q = SYNC_SECOND_RESET;
   logic       frame_open_q  = 1'b0;
   logic [7:0] bytes_left_q  = '0;
   logic [7:0] sum_a_q       = '0;
   logic [7:0] sum_b_q       = '0;

   wire_byte_type expected_bytes[$];
   int error_count   = 0;
   int counted_items = 0;
   int cycle_count   = 0;
   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;

   always #5 clock = ~clock;

   radio_frame_builder_fletcher dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_command_word (req_command_word),
      .req_frame_length (req_frame_length),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   function automatic void push_byte(logic [7:0] value, logic last);
      wire_byte_type wb;
      wb.value = value;
      wb.last  = last;
      expected_bytes.push_back(wb);
   endfunction

   function automatic void fold_sum(logic [7:0] b);
      sum_a_q = sum_a_q + b;
      sum_b_q = sum_b_q + sum_a_q;
   endfunction

   // Queues the frame bytes one item produces and returns how many there are.
   function automatic int predict_frame_bytes(logic cmd, logic [15:0] word, logic [7:0] len,
                                              logic [7:0] data);
      logic [7:0] hdr [HDR_LEN];
      logic [7:0] eff_len;
      int i;
      eff_len = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
      if (cmd == CMD_START) begin
         hdr[0] = sync_first_q;
         hdr[1] = sync_second_q;
         hdr[2] = word[15:8];
         hdr[3] = word[7:0];
         // The length goes out as 16 bits; its high byte is always zero here.
         hdr[4] = 8'h00;
         hdr[5] = eff_len;
         sum_a_q = '0;
         sum_b_q = '0;
         for (i = 2; i < HDR_LEN - 2; i++)
            fold_sum(hdr[i]);
         hdr[6] = sum_a_q;
         hdr[7] = sum_b_q;
         // The payload checksum carries on over the header checksum bytes.
         fold_sum(hdr[6]);
         fold_sum(hdr[7]);
         for (i = 0; i < HDR_LEN; i++)
            push_byte(hdr[i], (i == HDR_LEN - 1) && (eff_len == 0));
         frame_open_q = (eff_len != 0);
         bytes_left_q = eff_len;
         if (eff_len == 0) begin
            sum_a_q = '0;
            sum_b_q = '0;
         end
         return HDR_LEN;
      end
      if (!frame_open_q)
         return 0;
      fold_sum(data);
      push_byte(data, 1'b0);
      bytes_left_q = bytes_left_q - 8'd1;
      if (bytes_left_q != 0)
         return 1;
      push_byte(sum_a_q, 1'b0);
      push_byte(sum_b_q, 1'b1);
      frame_open_q = 1'b0;
      sum_a_q = '0;
      sum_b_q = '0;
      return 3;
   endfunction

   // Called just after a falling edge; returns just after a falling edge with valid still high.
   task automatic send_item(logic cmd, logic [15:0] word, logic [7:0] len, logic [7:0] data);
      logic accepted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_command_word <= word;
      req_frame_length <= len;
      req_data_byte    <= data;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = req_ready;
         if (accepted && predict_frame_bytes(cmd, word, len, data) > 0)
            counted_items++;
         @(negedge clock);
      end
   endtask

   task automatic send_start(logic [15:0] word, logic [7:0] len);
      send_item(CMD_START, word, len, 8'($urandom()));
   endtask

   task automatic send_payload(logic [7:0] data);
      send_item(CMD_DATA, 16'($urandom()), 8'($urandom()), data);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_sync_bytes(logic [7:0] first, logic [7:0] second);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SYNC_FIRST;
      csr_wdata        <= first;
      @(negedge clock);
      csr_index        <= CSR_SYNC_SECOND;
      csr_wdata        <= second;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sync_first_q  = first;
      sync_second_q = second;
   endtask

   task automatic test_default_headers();
      send_start(16'h0000, 8'd0);
      send_start(16'hFFFF, 8'd0);
      send_start(16'h1234, 8'd1);
      send_payload(8'hFF);
   endtask

   task automatic test_sync_extremes();
      wait_until_drained();
      write_sync_bytes(8'h00, 8'h00);
      send_start(16'h8001, 8'd0);
      wait_until_drained();
      write_sync_bytes(8'hFF, 8'hFF);
      send_start(16'h7FFE, 8'd2);
      send_payload(8'h00);
      send_payload(8'hFF);
   endtask

   task automatic test_stray_payload();
      send_payload(8'hAA);
      send_payload(8'h55);
      send_start(16'hA5A5, 8'd0);
   endtask

   task automatic test_abandoned_frame();
      send_start(16'h00FF, 8'd3);
      send_payload(8'h01);
      send_start(16'hFF00, 8'd1);
      send_payload(8'h80);
   endtask

   task automatic test_length_extremes();
      send_start(16'hC3C3, MAX_PAYLOAD);
      send_payload(8'($urandom()));
      send_payload(8'($urandom()));
      send_start(16'h0F0F, 8'd128);
      send_payload(8'($urandom()));
      send_start(16'h5555, 8'd1);
      send_payload(8'h7F);
   endtask

   task automatic test_long_frame();
      send_start(16'($urandom()), 8'd32);
      repeat (32) send_payload(8'($urandom()));
   endtask

   // Mostly complete frames with random content; the rest are frames cut short
   // by the next start and payload bytes that may find no frame open.
   task automatic test_random_frames(int items_wanted);
      int start_count;
      int pick;
      int len;
      int n;
      wait_until_drained();
      write_sync_bytes(8'($urandom()), 8'($urandom()));
      start_count = counted_items;
      while (counted_items - start_count < items_wanted) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            len = ($urandom_range(99) < 85) ? $urandom_range(6) : $urandom_range(40, 7);
            send_start(16'($urandom()), 8'(len));
            repeat (len) send_payload(8'($urandom()));
         end else if (pick < 88) begin
            len = $urandom_range(255, 1);
            n = $urandom_range((len < 6) ? len - 1 : 5);
            send_start(16'($urandom()), 8'(len));
            repeat (n) send_payload(8'($urandom()));
         end else begin
            repeat ($urandom_range(3, 1)) send_payload(8'($urandom()));
         end
      end
   endtask

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      wire_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("byte %02h with nothing expected", rsp_out_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.value)
               report_mismatch($sformatf("out_byte expected %02h got %02h",
                                         want.value, rsp_out_byte));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last expected %0b got %0b", want.last, rsp_last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      tx_idle_pct = 17;
      rx_idle_pct = 51;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_headers();
      test_sync_extremes();
      test_stray_payload();
      test_abandoned_frame();
      test_length_extremes();
      test_random_frames(20);

      wait_until_drained();
      tx_idle_pct = 51;
      rx_idle_pct = 17;
      test_long_frame();
      test_random_frames(20);

      wait_until_drained();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_frames(20);

      wait_until_drained();
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rfb_pkg.sv
rtl/rfb_framer.sv
rtl/rfb_burst_out.sv
rtl/radio_frame_builder_fletcher.sv
tb/testbench.sv
